@@ rtl/core/isoc_pkg.sv @@
// shared types, constants and saturation helpers for the imu calibrator
package isoc_pkg;

   localparam int NUM_LANES = 6;
   localparam int RAW_W     = 16;
   localparam int GAIN_W    = 18;
   localparam int GRAV_W    = 26;
   localparam int PROD_W    = RAW_W + GAIN_W + 1;
   localparam int SHIFT     = 8;
   localparam int OUT_W     = PROD_W - SHIFT;
   localparam int TOTAL_W   = 34;
   localparam int QUO_W     = TOTAL_W + 1;
   localparam int COUNT_W   = 10;
   localparam int DIV_STEPS = 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 2);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = GRAV_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY    = 2'd2;

   localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 18'd160727;
   localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 18'd35764;
   localparam logic [GRAV_W-1:0] GRAVITY_RST    = 26'd10286531;

   typedef struct packed {
      logic load;
      logic advance;
      logic accum;
      logic div_start;
      logic div_step;
      logic div_finish;
   } lane_ctrl_type;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OUT_W:0] v);
      logic signed [OUT_W-1:0] r;
      if (v[OUT_W] != v[OUT_W-1]) begin
         r = {v[OUT_W], {(OUT_W-1){~v[OUT_W]}}};
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [TOTAL_W-1:0] sat_total(input logic signed [TOTAL_W:0] v);
      logic signed [TOTAL_W-1:0] r;
      if (v[TOTAL_W] != v[TOTAL_W-1]) begin
         r = {v[TOTAL_W], {(TOTAL_W-1){~v[TOTAL_W]}}};
      end else begin
         r = v[TOTAL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_quo(input logic signed [QUO_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v[QUO_W-1:OUT_W-1] == {(QUO_W-OUT_W+1){v[QUO_W-1]}}) begin
         r = v[OUT_W-1:0];
      end else begin
         r = {v[QUO_W-1], {(OUT_W-1){~v[QUO_W-1]}}};
      end
      return r;
   endfunction

endpackage

@@ rtl/core/isoc_div.sv @@
// reciprocal-multiply divider of a signed total by a fixed sample count
module isoc_div #(
   parameter int unsigned DIVISOR = 100
) (
   input  logic                                 clock,
   input  logic                                 start,
   input  logic                                 step,
   input  logic signed [isoc_pkg::TOTAL_W-1:0]  dividend,
   output logic signed [isoc_pkg::QUO_W-1:0]    quot
);
   import isoc_pkg::*;

   localparam int unsigned DIV_D   = (DIVISOR < 1) ? 1 : DIVISOR;
   localparam int unsigned SH      = TOTAL_W + $clog2(DIV_D);
   localparam int unsigned HALF_W  = TOTAL_W / 2;
   localparam int unsigned RECIP_W = TOTAL_W + 1;
   localparam int unsigned ACC_W   = HALF_W + RECIP_W + 1;
   localparam logic [63:0] RECIP_WIDE = ((64'd1 << SH) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);

   logic [TOTAL_W-1:0] mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               first_ff, first_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [HALF_W-1:0]  part;
   logic [ACC_W-2:0]   prod;
   logic [TOTAL_W-1:0] quo_mag;

   // low half of the magnitude first, then high half plus carried upper bits
   always_comb begin
      part     = first_ff ? mag_ff[HALF_W-1:0] : mag_ff[TOTAL_W-1:HALF_W];
      prod     = part * RECIP;
      quo_mag  = TOTAL_W'(acc_ff >> (SH - HALF_W));
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      first_in = first_ff;
      acc_in   = acc_ff;
      if (start) begin
         mag_in   = dividend[TOTAL_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
         neg_in   = dividend[TOTAL_W-1];
         first_in = 1'b1;
      end else if (step) begin
         first_in = 1'b0;
         acc_in   = first_ff ? {1'b0, prod} : {1'b0, prod} + (acc_ff >> HALF_W);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      first_ff <= first_in;
      acc_ff   <= acc_in;
   end

   assign quot = neg_ff ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});

endmodule

@@ rtl/core/isoc_lane.sv @@
// one axis lane: gain multiply, bias removal, accumulation and bias update
module isoc_lane #(
   parameter int unsigned CAL_SAMPLES = 100
) (
   input  logic                                clock,
   input  logic                                reset,
   input  isoc_pkg::lane_ctrl_type             ctrl,
   input  logic signed [isoc_pkg::RAW_W-1:0]   raw,
   input  logic        [isoc_pkg::GAIN_W-1:0]  gain,
   input  logic        [isoc_pkg::GRAV_W-1:0]  offset,
   output logic signed [isoc_pkg::OUT_W-1:0]   corr
);
   import isoc_pkg::*;

   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [OUT_W-1:0]   bias_ff, bias_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic signed [OUT_W-1:0]   corr_ff, corr_in;
   logic signed [OUT_W-1:0]   scaled;
   logic signed [OUT_W:0]     diff;
   logic signed [TOTAL_W:0]   sum;
   logic signed [TOTAL_W-1:0] total_next;
   logic signed [QUO_W-1:0]   quot;
   logic signed [OUT_W-1:0]   quot_sat;
   logic signed [OUT_W:0]     bias_diff;

   isoc_div #(.DIVISOR(CAL_SAMPLES)) u_div (
      .clock    (clock),
      .start    (ctrl.div_start),
      .step     (ctrl.div_step),
      .dividend (total_next),
      .quot     (quot)
   );

   always_comb begin
      prod_in    = ctrl.load ? raw * $signed({1'b0, gain}) : prod_ff;
      scaled     = prod_ff[PROD_W-1:SHIFT];
      diff       = {scaled[OUT_W-1], scaled} - {bias_ff[OUT_W-1], bias_ff};
      corr_in    = ctrl.advance ? sat_out(diff) : corr_ff;
      sum        = {{(TOTAL_W+1-OUT_W){scaled[OUT_W-1]}}, scaled}
                   + {total_ff[TOTAL_W-1], total_ff};
      total_next = sat_total(sum);
      total_in   = total_ff;
      if (ctrl.div_start) begin
         total_in = '0;
      end else if (ctrl.accum) begin
         total_in = total_next;
      end
      quot_sat  = sat_quo(quot);
      bias_diff = {quot_sat[OUT_W-1], quot_sat} - $signed({2'b00, offset});
      bias_in   = ctrl.div_finish ? sat_out(bias_diff) : bias_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      corr_ff <= corr_in;
      if (reset) begin
         bias_ff  <= '0;
         total_ff <= '0;
      end else begin
         bias_ff  <= bias_in;
         total_ff <= total_in;
      end
   end

   assign corr = corr_ff;

endmodule

@@ rtl/core/imu_scale_offset_calibrator.sv @@
// top level: six axis lanes, calibration sequencing and response merge
//
// requests carry a command bit and six raw 16-bit words (three accel, three
// gyro). cmd 0 measures: each word is scaled by its gain, shifted down by 8,
// has its stored offset removed and is saturated to 27 bits. cmd 1 does the
// same and also adds the scaled, uncorrected values into six running sums.
// the request that completes a calibration run returns cal_done high; its own
// outputs still use the previous offsets.
// a request passes through the product register, then the output register.
// one request is taken per cycle while the response side keeps up and no
// offset divide is running; a held response stalls the lanes and
// back-pressures req_ready. at the end of a calibration run each lane
// divides its sum by the sample count with a reciprocal multiply split into a
// low-half and a high-half product; while the divide runs no request reaches
// the output stage (one more request may still be taken into the lanes).
// csr writes are always accepted; registers: accel gain, gyro gain, gravity.
// reset restores the register defaults and clears offsets, sums and counts.
module imu_scale_offset_calibrator #(
   parameter int unsigned CAL_SAMPLES = 100
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [isoc_pkg::RAW_W-1:0]    req_raw_accel_x,
   input  logic signed [isoc_pkg::RAW_W-1:0]    req_raw_accel_y,
   input  logic signed [isoc_pkg::RAW_W-1:0]    req_raw_accel_z,
   input  logic signed [isoc_pkg::RAW_W-1:0]    req_raw_gyro_x,
   input  logic signed [isoc_pkg::RAW_W-1:0]    req_raw_gyro_y,
   input  logic signed [isoc_pkg::RAW_W-1:0]    req_raw_gyro_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [isoc_pkg::OUT_W-1:0]    rsp_accel_x,
   output logic signed [isoc_pkg::OUT_W-1:0]    rsp_accel_y,
   output logic signed [isoc_pkg::OUT_W-1:0]    rsp_accel_z,
   output logic signed [isoc_pkg::OUT_W-1:0]    rsp_rate_x,
   output logic signed [isoc_pkg::OUT_W-1:0]    rsp_rate_y,
   output logic signed [isoc_pkg::OUT_W-1:0]    rsp_rate_z,
   output logic                                 rsp_cal_done,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [isoc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [isoc_pkg::CSR_DAT_W-1:0] csr_data
);
   import isoc_pkg::*;

   logic [GAIN_W-1:0]    accel_gain_ff, accel_gain_in;
   logic [GAIN_W-1:0]    gyro_gain_ff, gyro_gain_in;
   logic [GRAV_W-1:0]    gravity_ff, gravity_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_cmd_ff, s1_cmd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 cal_done_ff, cal_done_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [COUNT_W-1:0]   count_next;
   logic                 busy;
   logic                 complete;
   logic                 load;
   lane_ctrl_type        lane_ctrl;

   logic signed [RAW_W-1:0] raw   [NUM_LANES];
   logic        [GAIN_W-1:0] gain [NUM_LANES];
   logic        [GRAV_W-1:0] ofs  [NUM_LANES];
   logic signed [OUT_W-1:0] corr  [NUM_LANES];

   assign raw[0] = req_raw_accel_x;
   assign raw[1] = req_raw_accel_y;
   assign raw[2] = req_raw_accel_z;
   assign raw[3] = req_raw_gyro_x;
   assign raw[4] = req_raw_gyro_y;
   assign raw[5] = req_raw_gyro_z;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         gain[i] = (i < 3) ? accel_gain_ff : gyro_gain_ff;
         ofs[i]  = (i == 2) ? gravity_ff : '0;
      end
   end

   always_comb begin
      busy       = (div_cnt_ff != '0);
      count_next = count_ff + 1'b1;
      complete   = s1_cmd_ff && ((count_next == '0)
                   || (count_next >= COUNT_W'(CAL_SAMPLES)));

      lane_ctrl.advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready) && !busy;
      req_ready            = !s1_valid_ff || lane_ctrl.advance;
      load                 = req_valid && req_ready;
      lane_ctrl.load       = load;
      lane_ctrl.accum      = lane_ctrl.advance && s1_cmd_ff;
      lane_ctrl.div_start  = lane_ctrl.advance && complete;
      lane_ctrl.div_step   = (div_cnt_ff > DIV_CNT_W'(1));
      lane_ctrl.div_finish = (div_cnt_ff == DIV_CNT_W'(1));

      s1_valid_in = load ? 1'b1 : (lane_ctrl.advance ? 1'b0 : s1_valid_ff);
      s1_cmd_in   = load ? req_cmd : s1_cmd_ff;

      rsp_valid_in = lane_ctrl.advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      cal_done_in  = lane_ctrl.advance ? complete : cal_done_ff;

      count_in = count_ff;
      if (lane_ctrl.accum) begin
         count_in = complete ? '0 : count_next;
      end

      div_cnt_in = div_cnt_ff;
      if (lane_ctrl.div_start) begin
         div_cnt_in = DIV_CNT_W'(DIV_STEPS + 1);
      end else if (busy) begin
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      accel_gain_in = accel_gain_ff;
      gyro_gain_in  = gyro_gain_ff;
      gravity_in    = gravity_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACCEL_GAIN: accel_gain_in = csr_data[GAIN_W-1:0];
            CSR_GYRO_GAIN:  gyro_gain_in  = csr_data[GAIN_W-1:0];
            CSR_GRAVITY:    gravity_in    = csr_data[GRAV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= s1_cmd_in;
      cal_done_ff <= cal_done_in;
      if (reset) begin
         accel_gain_ff <= ACCEL_GAIN_RST;
         gyro_gain_ff  <= GYRO_GAIN_RST;
         gravity_ff    <= GRAVITY_RST;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         div_cnt_ff    <= '0;
      end else begin
         accel_gain_ff <= accel_gain_in;
         gyro_gain_ff  <= gyro_gain_in;
         gravity_ff    <= gravity_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      isoc_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .raw    (raw[g]),
         .gain   (gain[g]),
         .offset (ofs[g]),
         .corr   (corr[g])
      );
   end

   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cal_done = cal_done_ff;
   assign rsp_accel_x  = corr[0];
   assign rsp_accel_y  = corr[1];
   assign rsp_accel_z  = corr[2];
   assign rsp_rate_x   = corr[3];
   assign rsp_rate_y   = corr[4];
   assign rsp_rate_z   = corr[5];

   // offset divide keeps samples out of the output stage
   a_no_advance_busy: assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.div_start |=> busy && !lane_ctrl.advance)
      else $error("sample advanced during offset divide");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < COUNT_W'(CAL_SAMPLES))
      else $error("calibration count out of range");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.div_finish |=> !busy)
      else $error("divide sequencer did not return idle");

   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.advance |=> (rsp_cal_done == $past(complete)))
      else $error("cal_done does not match completed run");

endmodule

@@ sim/isoc_response_checker.sv @@
// response checker for the imu calibrator: predicts every response and compares it
`timescale 1ns / 100ps
module isoc_response_checker #(
   parameter int unsigned CAL_SAMPLES = 100
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic signed [isoc_pkg::RAW_W-1:0]     req_raw_accel_x,
   input  logic signed [isoc_pkg::RAW_W-1:0]     req_raw_accel_y,
   input  logic signed [isoc_pkg::RAW_W-1:0]     req_raw_accel_z,
   input  logic signed [isoc_pkg::RAW_W-1:0]     req_raw_gyro_x,
   input  logic signed [isoc_pkg::RAW_W-1:0]     req_raw_gyro_y,
   input  logic signed [isoc_pkg::RAW_W-1:0]     req_raw_gyro_z,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [isoc_pkg::OUT_W-1:0]     rsp_accel_x,
   input  logic signed [isoc_pkg::OUT_W-1:0]     rsp_accel_y,
   input  logic signed [isoc_pkg::OUT_W-1:0]     rsp_accel_z,
   input  logic signed [isoc_pkg::OUT_W-1:0]     rsp_rate_x,
   input  logic signed [isoc_pkg::OUT_W-1:0]     rsp_rate_y,
   input  logic signed [isoc_pkg::OUT_W-1:0]     rsp_rate_z,
   input  logic                                  rsp_cal_done,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [isoc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [isoc_pkg::CSR_DAT_W-1:0]        csr_data,
   output int                                    error_count,
   output int                                    results_seen,
   output int                                    cal_samples_seen,
   output int                                    cal_runs_seen,
   output int                                    saturated_seen
);
   import isoc_pkg::*;

   localparam longint DIVISOR = (CAL_SAMPLES < 1) ? 1 : CAL_SAMPLES;

   typedef struct packed {
      logic [NUM_LANES-1:0][OUT_W-1:0] lane;
      logic                            cal_done;
   } corrected_sample_type;

   corrected_sample_type corrected_q [$];

   logic [GAIN_W-1:0]         accel_gain;
   logic [GAIN_W-1:0]         gyro_gain;
   logic [GRAV_W-1:0]         gravity;
   logic signed [OUT_W-1:0]   offset [NUM_LANES];
   logic signed [TOTAL_W-1:0] running_sum [NUM_LANES];
   logic [COUNT_W-1:0]        cal_count;

   function automatic longint clamp(input longint v, input int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic string lane_name(input int i);
      case (i)
         0: return "accel_x";
         1: return "accel_y";
         2: return "accel_z";
         3: return "rate_x";
         4: return "rate_y";
         default: return "rate_z";
      endcase
   endfunction

   function automatic corrected_sample_type predict_sample(
      input logic calibrate, input logic [NUM_LANES-1:0][RAW_W-1:0] raw);
      longint               scaled [NUM_LANES];
      longint               product;
      logic [COUNT_W-1:0]   next_count;
      corrected_sample_type r;
      int                   i;
      for (i = 0; i < NUM_LANES; i++) begin
         product = longint'($signed(raw[i])) * longint'(i < 3 ? accel_gain : gyro_gain);
         scaled[i] = product >>> SHIFT;
         r.lane[i] = OUT_W'(clamp(scaled[i] - longint'(offset[i]), OUT_W));
      end
      r.cal_done = 1'b0;
      if (calibrate) begin
         for (i = 0; i < NUM_LANES; i++) begin
            running_sum[i] = TOTAL_W'(clamp(longint'(running_sum[i]) + scaled[i], TOTAL_W));
         end
         next_count = cal_count + 1'b1;
         if (next_count == '0 || next_count >= CAL_SAMPLES) begin
            for (i = 0; i < NUM_LANES; i++) begin
               offset[i] = OUT_W'(clamp(longint'(running_sum[i]) / DIVISOR, OUT_W));
               running_sum[i] = '0;
            end
            offset[2] = OUT_W'(clamp(longint'(offset[2]) - longint'(gravity), OUT_W));
            next_count = '0;
            r.cal_done = 1'b1;
         end
         cal_count = next_count;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      corrected_sample_type want;
      corrected_sample_type got;
      int                   i;
      if (reset) begin
         accel_gain = ACCEL_GAIN_RST;
         gyro_gain = GYRO_GAIN_RST;
         gravity = GRAVITY_RST;
         for (i = 0; i < NUM_LANES; i++) begin
            offset[i] = '0;
            running_sum[i] = '0;
         end
         cal_count = '0;
         corrected_q.delete();
         error_count = 0;
         cal_samples_seen = 0;
         cal_runs_seen = 0;
         saturated_seen = 0;
         results_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            got.lane = {rsp_rate_z, rsp_rate_y, rsp_rate_x,
                        rsp_accel_z, rsp_accel_y, rsp_accel_x};
            got.cal_done = rsp_cal_done;
            for (i = 0; i < NUM_LANES; i++) begin
               if (got.lane[i] == {1'b0, {(OUT_W-1){1'b1}}} ||
                   got.lane[i] == {1'b1, {(OUT_W-1){1'b0}}}) begin
                  saturated_seen++;
               end
            end
            if (corrected_q.size() == 0) begin
               if (error_count < 10) $display("response with no request outstanding");
               error_count++;
            end else begin
               want = corrected_q.pop_front();
               for (i = 0; i < NUM_LANES; i++) begin
                  if (got.lane[i] !== want.lane[i]) begin
                     if (error_count < 10) begin
                        $display("mismatch on %s: expected %0d, got %0d", lane_name(i),
                                 $signed(want.lane[i]), $signed(got.lane[i]));
                     end
                     error_count++;
                  end
               end
               if (got.cal_done !== want.cal_done) begin
                  if (error_count < 10) begin
                     $display("mismatch on cal_done: expected %0d, got %0d",
                              want.cal_done, got.cal_done);
                  end
                  error_count++;
               end
               if (want.cal_done) cal_runs_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEL_GAIN: accel_gain = csr_data[GAIN_W-1:0];
               CSR_GYRO_GAIN:  gyro_gain = csr_data[GAIN_W-1:0];
               CSR_GRAVITY:    gravity = csr_data[GRAV_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_cmd) cal_samples_seen++;
            corrected_q.push_back(predict_sample(req_cmd,
               {req_raw_gyro_z, req_raw_gyro_y, req_raw_gyro_x,
                req_raw_accel_z, req_raw_accel_y, req_raw_accel_x}));
         end
      end
   end

endmodule

@@ sim/imu_scale_offset_calibrator_tb.sv @@
// testbench top for the imu calibrator: clock, reset, request and register stimulus, verdict
`timescale 1ns / 100ps
module imu_scale_offset_calibrator_tb;
   import isoc_pkg::*;

   localparam int CAL_SAMPLES  = 100;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_CYCLES = 300;
   localparam int PHASE_ITEMS  = 210;

   localparam logic CMD_MEASURE   = 1'b0;
   localparam logic CMD_CALIBRATE = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
   localparam logic [GRAV_W-1:0] GRAV_MAX = '1;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_cmd = CMD_MEASURE;
   logic signed [RAW_W-1:0]  req_raw_accel_x = '0;
   logic signed [RAW_W-1:0]  req_raw_accel_y = '0;
   logic signed [RAW_W-1:0]  req_raw_accel_z = '0;
   logic signed [RAW_W-1:0]  req_raw_gyro_x = '0;
   logic signed [RAW_W-1:0]  req_raw_gyro_y = '0;
   logic signed [RAW_W-1:0]  req_raw_gyro_z = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]  rsp_accel_x;
   logic signed [OUT_W-1:0]  rsp_accel_y;
   logic signed [OUT_W-1:0]  rsp_accel_z;
   logic signed [OUT_W-1:0]  rsp_rate_x;
   logic signed [OUT_W-1:0]  rsp_rate_y;
   logic signed [OUT_W-1:0]  rsp_rate_z;
   logic                     rsp_cal_done;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_ACCEL_GAIN;
   logic [CSR_DAT_W-1:0]     csr_data = '0;

   int   send_idle_pct = 14;
   int   recv_idle_pct = 45;
   int   sent_count = 0;
   int   cycle_count = 0;
   logic stall_go = 1'b0;
   logic long_stall = 1'b0;

   int   error_count;
   int   results_seen;
   int   cal_samples_seen;
   int   cal_runs_seen;
   int   saturated_seen;

   always #4 clock = ~clock;

   imu_scale_offset_calibrator #(.CAL_SAMPLES(CAL_SAMPLES)) DUT (.*);

   isoc_response_checker #(.CAL_SAMPLES(CAL_SAMPLES)) response_check (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !long_stall && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off so the block backs up into req_ready
   initial begin
      wait (stall_go);
      @(posedge clock);
      long_stall <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      long_stall <= 1'b0;
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_registers(input logic [GAIN_W-1:0] accel_gain,
                                    input logic [GAIN_W-1:0] gyro_gain,
                                    input logic [GRAV_W-1:0] gravity);
      write_csr(CSR_ACCEL_GAIN, CSR_DAT_W'(accel_gain));
      write_csr(CSR_GYRO_GAIN, CSR_DAT_W'(gyro_gain));
      write_csr(CSR_GRAVITY, CSR_DAT_W'(gravity));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic cmd, input logic [NUM_LANES-1:0][RAW_W-1:0] raw);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_raw_accel_x <= raw[0];
      req_raw_accel_y <= raw[1];
      req_raw_accel_z <= raw[2];
      req_raw_gyro_x <= raw[3];
      req_raw_gyro_y <= raw[4];
      req_raw_gyro_z <= raw[5];
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // wait for every response, then let a pending offset division finish
   task automatic end_phase();
      req_valid <= 1'b0;
      while (results_seen < sent_count) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] random_word();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      if (pick == 1) return RAW_W'($urandom_range(600) - 300);
      return RAW_W'($urandom);
   endfunction

   task automatic run_random(input int count);
      logic [NUM_LANES-1:0][RAW_W-1:0] raw;
      int n;
      int k;
      for (n = 0; n < count; n++) begin
         for (k = 0; k < NUM_LANES; k++) raw[k] = random_word();
         send_sample(($urandom_range(99) < 75) ? CMD_CALIBRATE : CMD_MEASURE, raw);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of the raw words at full gain and full gravity
      program_registers(GAIN_MAX, GAIN_MAX, GRAV_MAX);
      send_sample(CMD_MEASURE, {6{16'h7FFF}});
      send_sample(CMD_MEASURE, {6{16'h8000}});
      send_sample(CMD_MEASURE, {16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000});
      send_sample(CMD_CALIBRATE, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
      send_sample(CMD_CALIBRATE, {6{16'hFFFF}});
      send_sample(CMD_MEASURE, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
      end_phase();

      program_registers('0, '0, '0);
      send_sample(CMD_MEASURE, {6{16'h7FFF}});
      send_sample(CMD_CALIBRATE, {6{16'h8000}});
      send_sample(CMD_MEASURE, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
      end_phase();

      // unit gain: floor rounding of negative products
      program_registers(GAIN_W'(1), GAIN_W'(1), GRAV_W'(1));
      send_sample(CMD_MEASURE, {16'h0100, 16'hFEFF, 16'hFF00, 16'hFF01, 16'h00FF, 16'hFFFF});
      send_sample(CMD_CALIBRATE, {16'h0100, 16'hFEFF, 16'hFF00, 16'hFF01, 16'h00FF, 16'hFFFF});
      end_phase();

      program_registers(ACCEL_GAIN_RST, GYRO_GAIN_RST, GRAVITY_RST);
      run_random(PHASE_ITEMS);
      end_phase();

      send_idle_pct = 45;
      recv_idle_pct = 14;
      program_registers(GAIN_W'($urandom), GAIN_W'($urandom), GRAV_W'($urandom));
      run_random(PHASE_ITEMS);
      end_phase();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_registers(GAIN_MAX, GAIN_MAX, GRAV_MAX);
      run_random(PHASE_ITEMS / 4);
      stall_go = 1'b1;
      run_random(PHASE_ITEMS - PHASE_ITEMS / 4);
      end_phase();

      $display("summary: %0d requests, %0d calibration samples, %0d calibration runs completed",
               sent_count, cal_samples_seen, cal_runs_seen);
      $display("summary: %0d responses, %0d saturated output words, %0d mismatches",
               results_seen, saturated_seen, error_count);
      if (error_count == 0 && results_seen == sent_count) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ imu_scale_offset_calibrator.f @@
rtl/core/isoc_pkg.sv
rtl/core/isoc_div.sv
rtl/core/isoc_lane.sv
rtl/core/imu_scale_offset_calibrator.sv
sim/isoc_response_checker.sv
sim/imu_scale_offset_calibrator_tb.sv
